[rtl/core/nrsp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constants for the nearest ray-sphere pick block.
// Used by every module under rtl/core; depends on nothing else.
package nrsp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 32;
  localparam int DIR_W      = 18;
  localparam int SCALE_W    = 31;
  localparam int ID_W       = 32;
  localparam int KIND_W     = 2;
  localparam int DIST_W     = 31;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;

  localparam int OX_W       = COORD_W + 1;
  localparam int MUL_W      = OX_W + 1;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int B_W        = 53;
  localparam int BMAG_W     = B_W - 1;
  localparam int HALF_W     = BMAG_W / 2;
  localparam int SQ_W       = 66;
  localparam int DSQ_W      = 36;
  localparam int DISC_W     = 2 * BMAG_W;
  localparam int ROOT_W     = DISC_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CNT_W      = $clog2(ROOT_W);
  localparam int T_W        = ROOT_W + 2;
  localparam int TQ_W       = T_W - FRAC_BITS;
  localparam int PSUM_W     = PROD_W - FRAC_BITS + 1;
  localparam int STEP_W     = 4;

  localparam int IN_DATA_W  = 224;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 160;

  // Radius constants in Q.F
  localparam logic [SCALE_W-1:0] RADIUS_PLANAR = SCALE_W'((64'd5 << FRAC_BITS) >> 1);
  localparam logic [SCALE_W-1:0] RADIUS_LIGHT  =
    SCALE_W'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
  localparam logic [SCALE_W-1:0] SCALE_MIN     =
    SCALE_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  // Threshold for dir.dir below 1e-12 in Q.2F
  localparam logic [DSQ_W-1:0] DSQ_THR =
    DSQ_W'(((64'd1 << (2 * FRAC_BITS)) - 64'd1) / 64'd1000000000000);

  localparam logic [KIND_W-1:0] KIND_PLANAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LIGHT  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  localparam logic [DIR_W-1:0] DIR_Z_RESET = DIR_W'(64'd1 << FRAC_BITS);

  // Multiply sequence, one issue per step
  localparam logic [STEP_W-1:0] STEP_B_X     = 4'd0;
  localparam logic [STEP_W-1:0] STEP_B_Y     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_B_Z     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SQ_X    = 4'd3;
  localparam logic [STEP_W-1:0] STEP_SQ_Y    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SQ_Z    = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RR      = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DSQ_X   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DSQ_Y   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DSQ_Z   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_BB_HH   = 4'd10;
  localparam logic [STEP_W-1:0] STEP_BB_HL   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_BB_LL   = 4'd12;
  localparam logic [STEP_W-1:0] STEP_MUL_END = 4'd13;
  localparam logic [STEP_W-1:0] STEP_PT_X    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_PT_Y    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_PT_Z    = 4'd2;
  localparam logic [STEP_W-1:0] STEP_PT_END  = 4'd3;

  // What to do with a product when it comes out of the multiplier
  typedef enum logic [3:0] {
    ACC_NONE,
    ACC_B,
    ACC_SQ,
    ACC_DSQ,
    ACC_RR,
    ACC_BB_HH,
    ACC_BB_HL,
    ACC_BB_LL,
    ACC_PT_X,
    ACC_PT_Y,
    ACC_PT_Z
  } acc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DISC,
    ST_SQRT,
    ST_ROOT,
    ST_POINT,
    ST_EMIT
  } state_t;

  function automatic logic [COORD_W-1:0] sat_coord(input logic [PSUM_W-1:0] v);
    logic [PSUM_W-COORD_W:0] top;
    top = v[PSUM_W-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[PSUM_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

[rtl/core/nrsp_mul.sv]
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product and a tag that rides along.
// Depends on nrsp_pkg.
module nrsp_mul (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [nrsp_pkg::MUL_W-1:0] a,
  input  logic signed [nrsp_pkg::MUL_W-1:0] b,
  input  nrsp_pkg::acc_op_t                 op,
  output logic signed [nrsp_pkg::PROD_W-1:0] prod,
  output nrsp_pkg::acc_op_t                 prod_op
);
  import nrsp_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= ACC_NONE;
    end else begin
      prod_op <= op;
    end
  end

endmodule

[rtl/core/nrsp_sqrt.sv]
`timescale 1ns / 1ps
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on nrsp_pkg.
module nrsp_sqrt (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [nrsp_pkg::DISC_W-1:0]        radicand,
  output logic                               done,
  output logic [nrsp_pkg::ROOT_W-1:0]        root
);
  import nrsp_pkg::*;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

  logic [DISC_W-1:0] rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [REM_W+1:0]  rem_sh;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W+1:0]  rem_sub;

  assign rem_sh  = {rem, rad[DISC_W-1 -: 2]};
  assign trial   = {2'b00, root, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= rad << 2;
      rem  <= ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
      root <= {root[ROOT_W-2:0], ge};
    end
  end

endmodule

[rtl/core/nearest_ray_sphere_pick.sv]
`timescale 1ns / 1ps
// Nearest ray-sphere pick: top level with sequencer, accumulators and result register.
// Depends on nrsp_pkg, nrsp_mul and nrsp_sqrt.
//
// Entities stream in one per transaction; those not hidden are tested against the
// configured ray as spheres. The nearest non-negative hit of the pass is kept and one
// result goes out on the transaction marked tlast, after which the kept hit is cleared.
// All arithmetic runs through one shared 34x34 multiplier, driven by a step sequencer,
// followed by a one-bit-per-cycle square root, and s_axis_tready is low while an
// entity is in flight. A hidden entity takes the shortest path, one where the ray
// misses the sphere or the direction is zero takes a longer one, and one where the
// root is taken takes the longest (the square root, with its 52 result bits, dominates);
// at the end of a pass the result register may also wait on m_axis_tready. Configure
// the ray only between entities.
module nearest_ray_sphere_pick (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [nrsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [nrsp_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // entity_id, center_x, center_y, center_z, scale_x, scale_y, scale_z, zero pad
  input  logic [nrsp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // entity_kind, is_hidden
  input  logic [nrsp_pkg::IN_USER_W-1:0]       s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // hit_object, hit_distance, hit_point_x, hit_point_y, hit_point_z, zero pad
  output logic [nrsp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // hit_found
  output logic                                 m_axis_tuser
);
  import nrsp_pkg::*;

  // configuration
  logic signed [COORD_W-1:0] org_x, org_y, org_z;
  logic signed [DIR_W-1:0]   dir_x, dir_y, dir_z;

  // current entity
  logic [ID_W-1:0]           ent_id;
  logic signed [OX_W-1:0]    ox_x, ox_y, ox_z;
  logic [SCALE_W-1:0]        radius;
  logic                      last_q;

  // input field views
  logic [ID_W-1:0]           in_id;
  logic [COORD_W-1:0]        in_cx, in_cy, in_cz;
  logic [SCALE_W-1:0]        in_sx, in_sy, in_sz;
  logic [KIND_W-1:0]         in_kind;
  logic                      in_hidden;
  logic                      in_acc;
  logic [SCALE_W-1:0]        scale_m0, scale_m1, scale_max;
  logic [SCALE_W+1:0]        scale_x3;
  logic [SCALE_W-1:0]        radius_in;

  // accumulators
  logic signed [B_W-1:0]     acc_b;
  logic [BMAG_W-1:0]         bmag;
  logic [SQ_W-1:0]           acc_sq;
  logic [DSQ_W-1:0]          acc_dsq;
  logic [DISC_W-1:0]         acc_bb;
  logic [DISC_W:0]           disc_diff;

  // root and distance
  logic signed [T_W-1:0]     neg_b, t_near, t_far, t_sel;
  logic [TQ_W-1:0]           t_q;
  logic [DIST_W-1:0]         pick_dist;
  logic                      dist_ok;
  logic                      better;
  logic signed [PSUM_W-1:0]  pt_sum;

  // kept hit
  logic                      best_valid;
  logic [COORD_W-1:0]        best_dist;
  logic [ID_W-1:0]           best_obj;
  logic [COORD_W-1:0]        best_px, best_py, best_pz;

  // result register
  logic                      out_valid;
  logic                      out_hit;
  logic [ID_W-1:0]           out_obj;
  logic [DIST_W-1:0]         out_dist;
  logic [COORD_W-1:0]        out_px, out_py, out_pz;

  // sequencer
  state_t                    state, state_next;
  logic [STEP_W-1:0]         step, step_next;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  acc_op_t                   mul_op;
  logic signed [PROD_W-1:0]  prod;
  acc_op_t                   prod_op;
  logic                      sq_start;
  logic                      sq_done;
  logic [ROOT_W-1:0]         sq_root;
  logic                      take_best;
  logic                      load_out;

  assign in_id     = s_axis_tdata[ID_W-1:0];
  assign in_cx     = s_axis_tdata[ID_W +: COORD_W];
  assign in_cy     = s_axis_tdata[ID_W + COORD_W +: COORD_W];
  assign in_cz     = s_axis_tdata[ID_W + 2 * COORD_W +: COORD_W];
  assign in_sx     = s_axis_tdata[ID_W + 3 * COORD_W +: SCALE_W];
  assign in_sy     = s_axis_tdata[ID_W + 3 * COORD_W + SCALE_W +: SCALE_W];
  assign in_sz     = s_axis_tdata[ID_W + 3 * COORD_W + 2 * SCALE_W +: SCALE_W];
  assign in_kind   = s_axis_tuser[KIND_W-1:0];
  assign in_hidden = s_axis_tuser[KIND_W];
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state == ST_IDLE);

  // radius: fixed for planar and light kinds, else 3/4 of the largest scale, at least SCALE_MIN
  assign scale_m0  = (in_sx > SCALE_MIN) ? in_sx : SCALE_MIN;
  assign scale_m1  = (in_sy > in_sz) ? in_sy : in_sz;
  assign scale_max = (scale_m1 > scale_m0) ? scale_m1 : scale_m0;
  assign scale_x3  = {1'b0, scale_max, 1'b0} + {2'b00, scale_max};

  always_comb begin
    case (in_kind)
      KIND_PLANAR: radius_in = RADIUS_PLANAR;
      KIND_LIGHT:  radius_in = RADIUS_LIGHT;
      default:     radius_in = scale_x3[SCALE_W+1:2];
    endcase
  end

  // b*b + r*r - |o-c|^2, all in Q.4F
  assign disc_diff = {1'b0, acc_bb} - ((DISC_W + 1)'(acc_sq) << (2 * FRAC_BITS));

  assign neg_b  = T_W'(0) - T_W'(acc_b);
  assign t_near = neg_b - T_W'(sq_root);
  assign t_far  = neg_b + T_W'(sq_root);
  assign t_sel  = t_near[T_W-1] ? t_far : t_near;
  assign t_q    = t_sel[T_W-1:FRAC_BITS];

  assign better = dist_ok && ({1'b0, pick_dist} < best_dist);
  assign pt_sum = PSUM_W'(prod >>> FRAC_BITS);

  nrsp_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .a       (mul_a),
    .b       (mul_b),
    .op      (mul_op),
    .prod    (prod),
    .prod_op (prod_op)
  );

  nrsp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (disc_diff[DISC_W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      org_x <= '0;
      org_y <= '0;
      org_z <= '0;
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= DIR_Z_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: org_x <= cfg_data;
        REG_ORIGIN_Y: org_y <= cfg_data;
        REG_ORIGIN_Z: org_z <= cfg_data;
        REG_DIR_X:    dir_x <= cfg_data[DIR_W-1:0];
        REG_DIR_Y:    dir_y <= cfg_data[DIR_W-1:0];
        REG_DIR_Z:    dir_z <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    mul_a      = '0;
    mul_b      = '0;
    mul_op     = ACC_NONE;
    sq_start   = 1'b0;
    take_best  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (s_axis_tvalid) begin
          state_next = in_hidden ? ST_EMIT : ST_MUL;
        end
      end
      ST_MUL: begin
        step_next = step + 1'b1;
        case (step)
          STEP_B_X: begin
            mul_a = MUL_W'(ox_x);  mul_b = MUL_W'(dir_x);  mul_op = ACC_B;
          end
          STEP_B_Y: begin
            mul_a = MUL_W'(ox_y);  mul_b = MUL_W'(dir_y);  mul_op = ACC_B;
          end
          STEP_B_Z: begin
            mul_a = MUL_W'(ox_z);  mul_b = MUL_W'(dir_z);  mul_op = ACC_B;
          end
          STEP_SQ_X: begin
            mul_a = MUL_W'(ox_x);  mul_b = MUL_W'(ox_x);   mul_op = ACC_SQ;
          end
          STEP_SQ_Y: begin
            mul_a = MUL_W'(ox_y);  mul_b = MUL_W'(ox_y);   mul_op = ACC_SQ;
          end
          STEP_SQ_Z: begin
            mul_a = MUL_W'(ox_z);  mul_b = MUL_W'(ox_z);   mul_op = ACC_SQ;
          end
          STEP_RR: begin
            mul_a = MUL_W'(radius); mul_b = MUL_W'(radius); mul_op = ACC_RR;
          end
          STEP_DSQ_X: begin
            mul_a = MUL_W'(dir_x); mul_b = MUL_W'(dir_x);  mul_op = ACC_DSQ;
          end
          STEP_DSQ_Y: begin
            mul_a = MUL_W'(dir_y); mul_b = MUL_W'(dir_y);  mul_op = ACC_DSQ;
          end
          STEP_DSQ_Z: begin
            mul_a = MUL_W'(dir_z); mul_b = MUL_W'(dir_z);  mul_op = ACC_DSQ;
          end
          // |b| split in halves: b^2 = hh<<2H + 2*hl<<H + ll
          STEP_BB_HH: begin
            mul_a  = MUL_W'(bmag[BMAG_W-1:HALF_W]);
            mul_b  = MUL_W'(bmag[BMAG_W-1:HALF_W]);
            mul_op = ACC_BB_HH;
          end
          STEP_BB_HL: begin
            mul_a  = MUL_W'(bmag[BMAG_W-1:HALF_W]);
            mul_b  = MUL_W'(bmag[HALF_W-1:0]);
            mul_op = ACC_BB_HL;
          end
          STEP_BB_LL: begin
            mul_a  = MUL_W'(bmag[HALF_W-1:0]);
            mul_b  = MUL_W'(bmag[HALF_W-1:0]);
            mul_op = ACC_BB_LL;
          end
          STEP_MUL_END: begin
            state_next = ST_DISC;
            step_next  = '0;
          end
          default: ;
        endcase
      end
      ST_DISC: begin
        if (acc_dsq > DSQ_THR && !disc_diff[DISC_W]) begin
          sq_start   = 1'b1;
          state_next = ST_SQRT;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_ROOT;
        end
      end
      ST_ROOT: begin
        state_next = ST_POINT;
        step_next  = '0;
      end
      ST_POINT: begin
        step_next = step + 1'b1;
        case (step)
          STEP_PT_X: begin
            if (better) begin
              take_best = 1'b1;
              mul_a     = MUL_W'(dir_x);
              mul_b     = MUL_W'(pick_dist);
              mul_op    = ACC_PT_X;
            end else begin
              state_next = ST_EMIT;
            end
          end
          STEP_PT_Y: begin
            mul_a = MUL_W'(dir_y);  mul_b = MUL_W'(pick_dist);  mul_op = ACC_PT_Y;
          end
          STEP_PT_Z: begin
            mul_a = MUL_W'(dir_z);  mul_b = MUL_W'(pick_dist);  mul_op = ACC_PT_Z;
          end
          STEP_PT_END: state_next = ST_EMIT;
          default: ;
        endcase
      end
      ST_EMIT: begin
        if (!last_q) begin
          state_next = ST_IDLE;
        end else if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // entity capture, accumulation and root distance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ent_id  <= in_id;
      ox_x    <= OX_W'(org_x) - OX_W'($signed(in_cx));
      ox_y    <= OX_W'(org_y) - OX_W'($signed(in_cy));
      ox_z    <= OX_W'(org_z) - OX_W'($signed(in_cz));
      radius  <= radius_in;
      last_q  <= s_axis_tlast;
      acc_b   <= '0;
      acc_sq  <= '0;
      acc_dsq <= '0;
      acc_bb  <= '0;
    end else begin
      case (prod_op)
        ACC_B:     acc_b   <= acc_b + B_W'(prod);
        ACC_SQ:    acc_sq  <= acc_sq + SQ_W'(prod);
        ACC_DSQ:   acc_dsq <= acc_dsq + DSQ_W'(prod);
        ACC_RR:    acc_bb  <= acc_bb + (DISC_W'(prod) << (2 * FRAC_BITS));
        ACC_BB_HH: acc_bb  <= acc_bb + (DISC_W'(prod) << (2 * HALF_W));
        ACC_BB_HL: acc_bb  <= acc_bb + (DISC_W'(prod) << (HALF_W + 1));
        ACC_BB_LL: acc_bb  <= acc_bb + DISC_W'(prod);
        default: ;
      endcase
    end
    bmag <= acc_b[B_W-1] ? BMAG_W'(-acc_b) : BMAG_W'(acc_b);
    if (state == ST_ROOT) begin
      dist_ok   <= !t_sel[T_W-1];
      pick_dist <= (|t_q[TQ_W-1:DIST_W]) ? {DIST_W{1'b1}} : t_q[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_dist  <= '1;
      best_obj   <= '0;
      best_px    <= '0;
      best_py    <= '0;
      best_pz    <= '0;
    end else begin
      if (take_best) begin
        best_valid <= 1'b1;
        best_dist  <= {1'b0, pick_dist};
        best_obj   <= ent_id;
      end else if (load_out) begin
        best_valid <= 1'b0;
        best_dist  <= '1;
        best_obj   <= '0;
        best_px    <= '0;
        best_py    <= '0;
        best_pz    <= '0;
      end
      case (prod_op)
        ACC_PT_X: best_px <= sat_coord(pt_sum + PSUM_W'(org_x));
        ACC_PT_Y: best_py <= sat_coord(pt_sum + PSUM_W'(org_y));
        ACC_PT_Z: best_pz <= sat_coord(pt_sum + PSUM_W'(org_z));
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_hit  <= best_valid;
      out_obj  <= best_valid ? best_obj : '0;
      out_dist <= best_valid ? best_dist[DIST_W-1:0] : '0;
      out_px   <= best_valid ? best_px : '0;
      out_py   <= best_valid ? best_py : '0;
      out_pz   <= best_valid ? best_pz : '0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_hit;
  assign m_axis_tdata  = {1'b0, out_pz, out_py, out_px, out_dist, out_obj};

  a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_SQRT)
    else $error("square root finished outside its wait state");

  a_best_cleared: assert property (@(posedge clk) disable iff (rst)
    !best_valid |-> best_dist == '1)
    else $error("kept distance not cleared while no hit is kept");

  a_best_saturated: assert property (@(posedge clk) disable iff (rst)
    best_valid |-> !best_dist[COORD_W-1])
    else $error("kept distance above saturation limit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
    else $error("result fields not zero on a miss");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state != ST_IDLE)
    else $error("sequencer did not start on an accepted entity");

endmodule
